// ===== src/dskr_pkg.sv =====
// dskr_pkg: shared types, constants and the quarter-wave sine table
// for the decaying sine kick roll. Depends on nothing.
package dskr_pkg;

  // Field widths fixed by the datapath
  localparam int unsigned SAMPLE_W = 24;   // Q1.23 input samples
  localparam int unsigned OUT_W    = 28;   // Q5.23 output samples
  localparam int unsigned AMP_W    = 27;   // Q4.23 amplitudes
  localparam int unsigned PHASE_W  = 32;   // phase accumulator, full turn = 2^32
  localparam int unsigned STEP_W   = 31;
  localparam int unsigned GAP_W    = 16;
  localparam int unsigned DECAY_W  = 16;   // Q0.16
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned SINE_W   = 23;   // sine magnitude, Q1.23 without sign
  localparam int unsigned CFG_W    = 31;   // widest register
  localparam int unsigned CFG_IDX_W = 3;

  // Register reset values
  localparam logic [STEP_W-1:0]  PHASE_STEP_RST   = STEP_W'(7158279);
  localparam logic [GAP_W-1:0]   GAP_LENGTH_RST   = GAP_W'(4800);
  localparam logic [DECAY_W-1:0] DECAY_FACTOR_RST = DECAY_W'(64225);
  localparam logic [COUNT_W-1:0] REPEAT_LIMIT_RST = COUNT_W'(7);
  localparam logic [AMP_W-1:0]   FIRST_AMP_RST    = AMP_W'(83886080);
  localparam logic [AMP_W-1:0]   RESTART_AMP_RST  = AMP_W'(16777216);
  localparam logic [AMP_W-1:0]   STOP_LEVEL_RST   = AMP_W'(83886);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_STEP   = 3'd0,
    CFG_GAP_LENGTH   = 3'd1,
    CFG_DECAY_FACTOR = 3'd2,
    CFG_REPEAT_LIMIT = 3'd3,
    CFG_FIRST_AMP    = 3'd4,
    CFG_RESTART_AMP  = 3'd5,
    CFG_STOP_LEVEL   = 3'd6
  } cfg_idx_e;

  // Quarter-wave table
  localparam int unsigned SINE_TABLE_DEPTH = 256;
  localparam int unsigned SINE_IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned FRAC_W = PHASE_W - 2;
  localparam int unsigned IDX_PROD_W = FRAC_W + SINE_IDX_W;

  typedef logic [SINE_W-1:0] sine_rom_t [0:SINE_TABLE_DEPTH];

  typedef struct packed {
    logic              neg;
    logic [SINE_W-1:0] mag;
  } sine_t;

  function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] p;
    p = a * b;
    return p >> 30;
  endfunction

  // Entry k = sin(pi/2 * k / depth): odd Taylor series to x^9 in Q2.30,
  // rounded half up to Q1.23 and clamped.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x, x2, x3, x5, x7, x9, pos, neg, v;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x   = (64'(k) << 30) / SINE_TABLE_DEPTH;
      x2  = mul_q30(x, x);
      x3  = mul_q30(x2, x);
      x5  = mul_q30(x3, x2);
      x7  = mul_q30(x5, x2);
      x9  = mul_q30(x7, x2);
      pos = mul_q30(64'd1686629713, x) + mul_q30(64'd85569306, x5)
          + mul_q30(64'd172272, x9);
      neg = mul_q30(64'd693598668, x3) + mul_q30(64'd5026995, x7);
      v   = (pos > neg) ? (pos - neg) : 64'd0;
      v   = (v + 64'd64) >> 7;
      if (v > 64'd8388607) v = 64'd8388607;
      rom[k] = v[SINE_W-1:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // Sine at phase zero
  localparam sine_t SINE_ZERO = '{neg: 1'b0, mag: SINE_ROM[0]};

endpackage

// ===== src/dskr_if.sv =====
// dskr_if: valid/ready word channels for the kick roll input and output.
// Depends on dskr_pkg for field widths.
interface dskr_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 trigger;
  logic signed [dskr_pkg::SAMPLE_W-1:0] left_in;
  logic signed [dskr_pkg::SAMPLE_W-1:0] right_in;

  modport source (output valid, trigger, left_in, right_in, input ready);
  modport sink   (input valid, trigger, left_in, right_in, output ready);
endinterface

interface dskr_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [dskr_pkg::OUT_W-1:0] left_out;
  logic signed [dskr_pkg::OUT_W-1:0] right_out;
  logic                              effect_active;

  modport source (output valid, left_out, right_out, effect_active, input ready);
  modport sink   (input valid, left_out, right_out, effect_active, output ready);
endinterface

// ===== src/dskr_sine.sv =====
// dskr_sine: quarter-wave table lookup of a 32-bit phase.
// Depends on dskr_pkg (table, widths, sine_t).
module dskr_sine (
  input  logic [dskr_pkg::PHASE_W-1:0] phase_i,
  output dskr_pkg::sine_t              sine_o
);

  logic [1:0]                          quad;
  logic [dskr_pkg::IDX_PROD_W-1:0]     idx_prod;
  logic [dskr_pkg::SINE_IDX_W-1:0]     idx_raw;
  logic [dskr_pkg::SINE_IDX_W-1:0]     idx;

  assign quad     = phase_i[dskr_pkg::PHASE_W-1 -: 2];
  // index = frac * depth >> 30, always below depth
  assign idx_prod = dskr_pkg::IDX_PROD_W'(phase_i[dskr_pkg::FRAC_W-1:0])
                  * dskr_pkg::IDX_PROD_W'(dskr_pkg::SINE_TABLE_DEPTH);
  assign idx_raw  = idx_prod[dskr_pkg::FRAC_W +: dskr_pkg::SINE_IDX_W];
  // odd quadrants run the table backward
  assign idx      = quad[0] ? (dskr_pkg::SINE_IDX_W'(dskr_pkg::SINE_TABLE_DEPTH) - idx_raw)
                            : idx_raw;

  assign sine_o.mag = dskr_pkg::SINE_ROM[idx];
  assign sine_o.neg = quad[1];

endmodule

// ===== src/decaying_sine_kick_roll.sv =====
// decaying_sine_kick_roll: top level, adds decaying sine bursts to a stereo stream.
// Depends on dskr_pkg, dskr_if (dskr_in_if, dskr_out_if) and dskr_sine.
//
//  channel  dir  word fields                        handshake
//  in_w     in   trigger, left_in, right_in         valid/ready, sink
//  out_w    out  left_out, right_out, effect_active valid/ready, source
//  cfg      in   cfg_idx_i, cfg_data_i              cfg_we_i, no stall
//
// One word a cycle while out_w takes every word; each result sits in the output
// register in the cycle after its input word is taken. The output register is the only
// stage: in_w.ready drops only while it holds a word that out_w does not take.
// Reset clears the effect state and loads the register defaults; no sweep.
// Stalls on out_w back up into in_w in the same cycle.
module decaying_sine_kick_roll (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  dskr_in_if.sink                            in_w,
  dskr_out_if.source                         out_w,
  input  logic                               cfg_we_i,
  input  logic [dskr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [dskr_pkg::CFG_W-1:0]         cfg_data_i
);

  localparam int unsigned TONE_PROD_W  = dskr_pkg::AMP_W + dskr_pkg::SINE_W;
  localparam int unsigned DECAY_PROD_W = dskr_pkg::AMP_W + dskr_pkg::DECAY_W;
  localparam int unsigned SUM_W        = dskr_pkg::OUT_W + 1;
  localparam int unsigned TONE_SHIFT   = 23;   // amplitude * sine / 2^23

  // ---------------- configuration registers ----------------
  logic [dskr_pkg::STEP_W-1:0]  phase_step_q;
  logic [dskr_pkg::GAP_W-1:0]   gap_length_q;
  logic [dskr_pkg::DECAY_W-1:0] decay_factor_q;
  logic [dskr_pkg::COUNT_W-1:0] repeat_limit_q;
  logic [dskr_pkg::AMP_W-1:0]   first_amp_q;
  logic [dskr_pkg::AMP_W-1:0]   restart_amp_q;
  logic [dskr_pkg::AMP_W-1:0]   stop_level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q   <= dskr_pkg::PHASE_STEP_RST;
      gap_length_q   <= dskr_pkg::GAP_LENGTH_RST;
      decay_factor_q <= dskr_pkg::DECAY_FACTOR_RST;
      repeat_limit_q <= dskr_pkg::REPEAT_LIMIT_RST;
      first_amp_q    <= dskr_pkg::FIRST_AMP_RST;
      restart_amp_q  <= dskr_pkg::RESTART_AMP_RST;
      stop_level_q   <= dskr_pkg::STOP_LEVEL_RST;
    end else if (cfg_we_i) begin
      unique case (dskr_pkg::cfg_idx_e'(cfg_idx_i))
        dskr_pkg::CFG_PHASE_STEP:   phase_step_q   <= cfg_data_i[dskr_pkg::STEP_W-1:0];
        dskr_pkg::CFG_GAP_LENGTH:   gap_length_q   <= cfg_data_i[dskr_pkg::GAP_W-1:0];
        dskr_pkg::CFG_DECAY_FACTOR: decay_factor_q <= cfg_data_i[dskr_pkg::DECAY_W-1:0];
        dskr_pkg::CFG_REPEAT_LIMIT: repeat_limit_q <= cfg_data_i[dskr_pkg::COUNT_W-1:0];
        dskr_pkg::CFG_FIRST_AMP:    first_amp_q    <= cfg_data_i[dskr_pkg::AMP_W-1:0];
        dskr_pkg::CFG_RESTART_AMP:  restart_amp_q  <= cfg_data_i[dskr_pkg::AMP_W-1:0];
        dskr_pkg::CFG_STOP_LEVEL:   stop_level_q   <= cfg_data_i[dskr_pkg::AMP_W-1:0];
        default: ;  // unused index, dropped
      endcase
    end
  end

  // ---------------- effect state ----------------
  logic                          running_q, running_d;
  logic [dskr_pkg::PHASE_W-1:0]  phase_q, phase_d;
  logic [dskr_pkg::AMP_W-1:0]    amp_q, amp_d;
  logic [dskr_pkg::COUNT_W-1:0]  count_q, count_d;
  logic [dskr_pkg::GAP_W-1:0]    gap_q, gap_d;
  dskr_pkg::sine_t               sine_q, sine_d;   // sine at phase_q, kept alongside it

  // ---------------- output register ----------------
  logic                          out_valid_q;
  logic signed [dskr_pkg::OUT_W-1:0] left_q, right_q, left_d, right_d;
  logic                          active_q;

  logic in_acc;
  assign in_w.ready = !out_valid_q || out_w.ready;
  assign in_acc     = in_w.valid && in_w.ready;

  // Trigger overrides the state seen by this word.
  logic                          run_src;
  logic [dskr_pkg::PHASE_W-1:0]  phase_src;
  logic [dskr_pkg::AMP_W-1:0]    amp_src;
  logic [dskr_pkg::COUNT_W-1:0]  count_src;
  logic [dskr_pkg::GAP_W-1:0]    gap_src;
  dskr_pkg::sine_t               sine_src;

  assign run_src   = in_w.trigger || running_q;
  assign phase_src = in_w.trigger ? '0 : phase_q;
  assign amp_src   = in_w.trigger ? first_amp_q : amp_q;
  assign count_src = in_w.trigger ? '0 : count_q;
  assign gap_src   = in_w.trigger ? '0 : gap_q;
  assign sine_src  = in_w.trigger ? dskr_pkg::SINE_ZERO : sine_q;

  // Advanced phase and its sine, looked up ahead so the tone multiply
  // never waits on the table index multiply.
  logic [dskr_pkg::PHASE_W-1:0] phase_adv;
  dskr_pkg::sine_t              sine_adv;
  assign phase_adv = phase_src + dskr_pkg::PHASE_W'(phase_step_q);

  dskr_sine u_sine (
    .phase_i (phase_adv),
    .sine_o  (sine_adv)
  );

  // Tone magnitude: round half away from zero on the magnitude.
  logic [TONE_PROD_W-1:0]          tone_prod;
  logic [dskr_pkg::AMP_W-1:0]      tone_mag;
  assign tone_prod = TONE_PROD_W'(amp_src) * TONE_PROD_W'(sine_src.mag)
                   + TONE_PROD_W'(1 << (TONE_SHIFT - 1));
  assign tone_mag  = tone_prod[TONE_SHIFT +: dskr_pkg::AMP_W];

  // Geometric decay, truncated
  logic [DECAY_PROD_W-1:0]     decay_prod;
  logic [dskr_pkg::AMP_W-1:0]  amp_decayed;
  assign decay_prod  = DECAY_PROD_W'(amp_src) * DECAY_PROD_W'(decay_factor_q);
  assign amp_decayed = decay_prod[dskr_pkg::DECAY_W +: dskr_pkg::AMP_W];

  logic [dskr_pkg::COUNT_W-1:0] count_inc;
  assign count_inc = (&count_src) ? count_src : count_src + 1'b1;   // saturates

  logic                   tone_on;
  logic signed [SUM_W-1:0] tone_s, left_sum, right_sum;

  always_comb begin
    running_d = running_q;
    phase_d   = phase_src;
    amp_d     = amp_src;
    count_d   = count_src;
    gap_d     = gap_src;
    sine_d    = sine_src;
    tone_on   = 1'b0;
    if (run_src) begin
      if (gap_src != '0) begin
        gap_d = gap_src - 1'b1;   // gap word passes through
      end else begin
        tone_on   = 1'b1;
        running_d = 1'b1;
        phase_d   = phase_adv;
        sine_d    = sine_adv;
        amp_d     = amp_decayed;
        if (amp_decayed < stop_level_q) begin
          // burst over: stop at the limit, else restart after a gap
          count_d = count_inc;
          if (count_inc >= repeat_limit_q) begin
            running_d = 1'b0;
          end else begin
            phase_d = '0;
            sine_d  = dskr_pkg::SINE_ZERO;
            amp_d   = restart_amp_q;
            gap_d   = gap_length_q;
          end
        end
      end
    end
  end

  always_comb begin
    tone_s = '0;
    if (tone_on) begin
      tone_s = sine_src.neg ? -$signed({2'b00, tone_mag}) : $signed({2'b00, tone_mag});
    end
    left_sum  = SUM_W'(in_w.left_in) + tone_s;
    right_sum = SUM_W'(in_w.right_in) + tone_s;
  end

  // Saturate to the Q5.23 range
  function automatic logic signed [dskr_pkg::OUT_W-1:0] sat_out(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [dskr_pkg::OUT_W-1:0] r;
    if (v[SUM_W-1] == v[SUM_W-2]) r = v[dskr_pkg::OUT_W-1:0];
    else if (v[SUM_W-1])          r = {1'b1, {(dskr_pkg::OUT_W-1){1'b0}}};
    else                          r = {1'b0, {(dskr_pkg::OUT_W-1){1'b1}}};
    return r;
  endfunction

  assign left_d  = sat_out(left_sum);
  assign right_d = sat_out(right_sum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q   <= 1'b0;
      phase_q     <= '0;
      amp_q       <= '0;
      count_q     <= '0;
      gap_q       <= '0;
      sine_q      <= dskr_pkg::SINE_ZERO;
      out_valid_q <= 1'b0;
      active_q    <= 1'b0;
    end else begin
      if (in_acc) begin
        running_q   <= running_d;
        phase_q     <= phase_d;
        amp_q       <= amp_d;
        count_q     <= count_d;
        gap_q       <= gap_d;
        sine_q      <= sine_d;
        out_valid_q <= 1'b1;
        active_q    <= running_d;
      end else if (out_w.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  assign out_w.valid         = out_valid_q;
  assign out_w.left_out      = left_q;
  assign out_w.right_out     = right_q;
  assign out_w.effect_active = active_q;

  // ---------------- assertions ----------------
  // Idle word without trigger never reports the effect running.
  a_idle_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !in_w.trigger && !running_q |=> !out_w.effect_active)
    else $error("effect became active without a trigger");

  // A held result always agrees with the live state.
  a_active_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (active_q == running_q))
    else $error("effect_active out of step with state");

  // A pending gap only exists while the effect runs.
  a_gap_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gap_q != '0) |-> running_q)
    else $error("gap pending while effect stopped");

  // Full output that is not taken must stall the input.
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_w.ready |-> !in_w.ready)
    else $error("input taken while output word stalled");

endmodule

// ===== verif/kick_roll_checker.sv =====
`timescale 1ns / 100ps
// kick_roll_checker: watches the frame words and register writes of the kick roll,
// predicts every output word and compares it field by field.
// Depends on dskr_pkg and the word channels in dskr_if.
module kick_roll_checker
  import dskr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  dskr_in_if                   in_w,
  dskr_out_if                  out_w,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o
);

  localparam longint OUT_HI = 134217727;
  localparam longint OUT_LO = -134217728;

  typedef struct packed {
    logic signed [OUT_W-1:0] left;
    logic signed [OUT_W-1:0] right;
    logic                    active;
  } mixed_frame_t;

  logic [SINE_W-1:0] quarter_wave [0:SINE_TABLE_DEPTH];

  // register copies
  logic [STEP_W-1:0]  step_reg;
  logic [GAP_W-1:0]   gap_len_reg;
  logic [DECAY_W-1:0] decay_reg;
  logic [COUNT_W-1:0] limit_reg;
  logic [AMP_W-1:0]   amp_first_reg, amp_restart_reg, amp_stop_reg;

  // effect state
  logic               run_on;
  logic [PHASE_W-1:0] phase;
  logic [AMP_W-1:0]   amp;
  logic [COUNT_W-1:0] bursts;
  logic [GAP_W-1:0]   gap_ctr;

  mixed_frame_t pending_mixes [$];
  mixed_frame_t want, got;

  // sin(pi/2 * k / depth) as an odd power series to x^9, Q2.30, signs alternate
  function automatic logic [SINE_W-1:0] quarter_wave_entry(input int unsigned k);
    logic [63:0] x, x_sq, power, coef, term, pos, neg;
    x     = k;
    x     = (x << 30) / SINE_TABLE_DEPTH;
    x_sq  = (x * x) >> 30;
    power = x;
    pos   = 0;
    neg   = 0;
    for (int n = 0; n < 5; n++) begin
      case (n)
        0: coef = 64'd1686629713;
        1: coef = 64'd693598668;
        2: coef = 64'd85569306;
        3: coef = 64'd5026995;
        default: coef = 64'd172272;
      endcase
      term = (coef * power) >> 30;
      if (n % 2 == 0) pos += term;
      else neg += term;
      power = (power * x_sq) >> 30;
    end
    pos = (pos > neg) ? pos - neg : 64'd0;
    pos = (pos + 64'd64) >> 7;
    if (pos > 64'd8388607) pos = 64'd8388607;
    return pos[SINE_W-1:0];
  endfunction

  function automatic logic signed [OUT_W-1:0] clamp_q5_23(input longint v);
    if (v > OUT_HI) v = OUT_HI;
    if (v < OUT_LO) v = OUT_LO;
    return v[OUT_W-1:0];
  endfunction

  // one frame through the effect; updates the state copy
  function automatic mixed_frame_t mix_tone_frame(input logic trig,
      input logic signed [SAMPLE_W-1:0] l_in, r_in);
    mixed_frame_t f;
    logic [1:0]   quad;
    int unsigned  idx;
    logic [63:0]  t;
    longint       tone;
    tone = 0;
    if (trig) begin
      run_on  = 1'b1;
      phase   = '0;
      amp     = amp_first_reg;
      bursts  = '0;
      gap_ctr = '0;
    end
    if (run_on) begin
      if (gap_ctr != 0) begin
        gap_ctr--;
      end else begin
        quad = phase[PHASE_W-1 -: 2];
        t    = phase[PHASE_W-3:0];
        idx  = (t * SINE_TABLE_DEPTH) >> (PHASE_W - 2);
        if (quad[0]) idx = SINE_TABLE_DEPTH - idx;
        t    = amp;
        t    = (t * quarter_wave[idx] + 64'd4194304) >> 23;
        tone = quad[1] ? -longint'(t) : longint'(t);
        phase = phase + {1'b0, step_reg};
        t    = amp;
        t    = (t * decay_reg) >> 16;
        amp  = t[AMP_W-1:0];
        if (amp < amp_stop_reg) begin
          if (bursts != 8'd255) bursts++;
          if (bursts >= limit_reg) begin
            run_on = 1'b0;
          end else begin
            phase   = '0;
            amp     = amp_restart_reg;
            gap_ctr = gap_len_reg;
          end
        end
      end
    end
    f.left   = clamp_q5_23(longint'(l_in) + tone);
    f.right  = clamp_q5_23(longint'(r_in) + tone);
    f.active = run_on;
    return f;
  endfunction

  initial begin
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) quarter_wave[k] = quarter_wave_entry(k);
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_reg        = PHASE_STEP_RST;
      gap_len_reg     = GAP_LENGTH_RST;
      decay_reg       = DECAY_FACTOR_RST;
      limit_reg       = REPEAT_LIMIT_RST;
      amp_first_reg   = FIRST_AMP_RST;
      amp_restart_reg = RESTART_AMP_RST;
      amp_stop_reg    = STOP_LEVEL_RST;
      run_on          = 1'b0;
      phase           = '0;
      amp             = '0;
      bursts          = '0;
      gap_ctr         = '0;
      pending_mixes.delete();
      fail_count_o    = 0;
      pending_o       = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_PHASE_STEP:   step_reg        = cfg_data_i[STEP_W-1:0];
          CFG_GAP_LENGTH:   gap_len_reg     = cfg_data_i[GAP_W-1:0];
          CFG_DECAY_FACTOR: decay_reg       = cfg_data_i[DECAY_W-1:0];
          CFG_REPEAT_LIMIT: limit_reg       = cfg_data_i[COUNT_W-1:0];
          CFG_FIRST_AMP:    amp_first_reg   = cfg_data_i[AMP_W-1:0];
          CFG_RESTART_AMP:  amp_restart_reg = cfg_data_i[AMP_W-1:0];
          CFG_STOP_LEVEL:   amp_stop_reg    = cfg_data_i[AMP_W-1:0];
          default: ;  // unused index, no effect
        endcase
      end
      // retire before predicting: a word taken now cannot be answered this edge
      if (out_w.valid && out_w.ready) begin
        got.left   = out_w.left_out;
        got.right  = out_w.right_out;
        got.active = out_w.effect_active;
        if (pending_mixes.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("output word with no frame pending: left %0d right %0d active %0b",
                     got.left, got.right, got.active);
        end else begin
          want = pending_mixes.pop_front();
          if (got.left !== want.left || got.right !== want.right ||
              got.active !== want.active) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("frame mismatch: expected left %0d right %0d active %0b, got left %0d right %0d active %0b",
                       want.left, want.right, want.active, got.left, got.right, got.active);
          end
        end
      end
      if (in_w.valid && in_w.ready)
        pending_mixes.push_back(mix_tone_frame(in_w.trigger, in_w.left_in, in_w.right_in));
      pending_o = pending_mixes.size();
    end
  end

endmodule

// ===== verif/tb_decaying_sine_kick_roll.sv =====
`timescale 1ns / 100ps
// tb_decaying_sine_kick_roll: drives frame words and register writes into the kick roll
// and gives the verdict. Depends on dskr_pkg, dskr_if, the block and kick_roll_checker.
module tb_decaying_sine_kick_roll;
  import dskr_pkg::*;

  // Nothing taken on either channel for this long means the block is hung.
  localparam int unsigned WATCHDOG_LIMIT   = 2000;
  // Receiver hold-off used to fill the output register and back up the input.
  localparam int unsigned LONG_HOLD_CYCLES = 80;
  // Index past the last register; the block must ignore the write.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
  localparam int unsigned RANDOM_PHASES    = 14;
  localparam int unsigned FRAMES_PER_PHASE = 95;
  localparam int unsigned LONG_ROLL_FRAMES = 270;

  typedef enum int {PACE_FULL, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_e;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  dskr_in_if  in_w ();
  dskr_out_if out_w ();

  int unsigned mix_fail_count, pending_mixes;
  int unsigned send_idle_pct, recv_stall_pct;
  int unsigned holds_asked, holds_served, hold_left;
  int unsigned quiet_cycles;

  // per-phase register picks
  logic [STEP_W-1:0]  step_v;
  logic [GAP_W-1:0]   gap_v;
  logic [DECAY_W-1:0] decay_v;
  logic [COUNT_W-1:0] limit_v;
  logic [AMP_W-1:0]   first_v, restart_v, stop_v;

  always #1 clk_i = ~clk_i;

  decaying_sine_kick_roll dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_w       (in_w),
    .out_w      (out_w),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  kick_roll_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_w         (in_w),
    .out_w        (out_w),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (mix_fail_count),
    .pending_o    (pending_mixes)
  );

  // Output side. A long hold is asked by bumping holds_asked; this process
  // alone counts it down so the sender keeps pushing words meanwhile.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_w.ready <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      out_w.ready  <= 1'b0;
      hold_left    <= LONG_HOLD_CYCLES - 1;
      holds_served <= holds_served + 1;
    end else begin
      out_w.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: runs of cycles with no word taken on either channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_w.valid && in_w.ready) || (out_w.valid && out_w.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[decaying_sine_kick_roll] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_pace(input pace_e pace);
    send_idle_pct  = (pace == PACE_SEND_IDLE) ? 69 : (pace == PACE_BOTH) ? 12 : 0;
    recv_stall_pct = (pace == PACE_RECV_STALL) ? 69 : (pace == PACE_BOTH) ? 12 : 0;
  endtask

  // Offer one frame word, with random idle cycles ahead of it, and return
  // right after the edge that takes it. valid stays high for a following word.
  task automatic send_frame(input logic trig, input logic [SAMPLE_W-1:0] l_smp, r_smp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_w.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_w.valid    <= 1'b1;
    in_w.trigger  <= trig;
    in_w.left_in  <= l_smp;
    in_w.right_in <= r_smp;
    do @(posedge clk_i); while (!in_w.ready);
  endtask

  // Registers change only with the block drained. The edge after valid drops
  // makes sure the last word is already counted as pending.
  task automatic program_regs(input logic [STEP_W-1:0] step, input logic [GAP_W-1:0] gap,
                              input logic [DECAY_W-1:0] decay, input logic [COUNT_W-1:0] limit,
                              input logic [AMP_W-1:0] first, restart, stop);
    in_w.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_mixes != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_PHASE_STEP;   cfg_data_i <= CFG_W'(step);    @(posedge clk_i);
    cfg_idx_i <= CFG_GAP_LENGTH;   cfg_data_i <= CFG_W'(gap);     @(posedge clk_i);
    cfg_idx_i <= CFG_DECAY_FACTOR; cfg_data_i <= CFG_W'(decay);   @(posedge clk_i);
    cfg_idx_i <= CFG_REPEAT_LIMIT; cfg_data_i <= CFG_W'(limit);   @(posedge clk_i);
    cfg_idx_i <= CFG_FIRST_AMP;    cfg_data_i <= CFG_W'(first);   @(posedge clk_i);
    cfg_idx_i <= CFG_RESTART_AMP;  cfg_data_i <= CFG_W'(restart); @(posedge clk_i);
    cfg_idx_i <= CFG_STOP_LEVEL;   cfg_data_i <= CFG_W'(stop);    @(posedge clk_i);
    cfg_idx_i <= CFG_UNUSED_IDX;   cfg_data_i <= CFG_W'($urandom); @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_w.valid    = 1'b0;
    in_w.trigger  = 1'b0;
    in_w.left_in  = '0;
    in_w.right_in = '0;
    out_w.ready   = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_PHASE_STEP;
    cfg_data_i    = '0;
    holds_asked   = 0;
    holds_served  = 0;
    hold_left     = 0;
    quiet_cycles  = 0;
    set_pace(PACE_FULL);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset defaults: idle pass-through at the sample extremes, then a trigger.
    send_frame(1'b0, 24'h7FFFFF, 24'h800000);
    send_frame(1'b0, 24'h800000, 24'h7FFFFF);
    send_frame(1'b1, 24'h000000, 24'h000000);
    send_frame(1'b0, 24'h3A5C01, 24'hC0FFEE);

    // Output saturation: widest amplitude, quarter-turn steps land on the
    // positive and negative peaks; zero stop level keeps the burst going.
    program_regs(31'h4000_0000, 16'd0, 16'hFFFF, 8'd7, 27'h7FF_FFFF, 27'h7FF_FFFF, 27'd0);
    send_frame(1'b1, 24'h7FFFFF, 24'h800000);
    repeat (4) send_frame(1'b0, 24'h7FFFFF, 24'h800000);

    // Repeat limit of zero: the first burst is also the last.
    program_regs(31'h0123_4567, 16'd3, 16'd0, 8'd0, 27'h100_0000, 27'h80_0000, 27'd1);
    send_frame(1'b1, 24'h001234, 24'hFEDCBA);
    repeat (2) send_frame(1'b0, 24'($urandom), 24'($urandom));

    // Gaps between bursts: halving decay ends the first burst on its third frame and
    // each restarted one on its second, then two pass-through frames before a restart.
    program_regs(31'h1000_0000, 16'd2, 16'h8000, 8'd3, 27'h200_0000, 27'h100_0000,
                 27'h80_0000);
    send_frame(1'b1, 24'($urandom), 24'($urandom));
    repeat (9) send_frame(1'b0, 24'($urandom), 24'($urandom));

    // Random phases: each starts with a trigger, so most words run through
    // bursts and gaps; further triggers land at random.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 12) begin
        step_v = '0; gap_v = '0; decay_v = '0; limit_v = '0;
        first_v = '0; restart_v = '0; stop_v = '0;
      end else if (p == 13) begin
        step_v = '1; gap_v = '1; decay_v = '1; limit_v = '1;
        first_v = '1; restart_v = '1; stop_v = '1;
      end else begin
        step_v    = ($urandom_range(3) == 0) ? 31'h4000_0000 : STEP_W'($urandom);
        gap_v     = ($urandom_range(7) == 0) ? GAP_W'($urandom) : GAP_W'($urandom_range(6));
        decay_v   = ($urandom_range(3) == 0) ? DECAY_W'($urandom)
                                             : DECAY_W'($urandom_range(62000, 30000));
        limit_v   = ($urandom_range(3) == 0) ? COUNT_W'($urandom)
                                             : COUNT_W'($urandom_range(5, 1));
        first_v   = AMP_W'($urandom);
        restart_v = AMP_W'($urandom);
        stop_v    = ($urandom_range(7) == 0) ? AMP_W'($urandom)
                                             : first_v >> $urandom_range(6, 1);
      end
      program_regs(step_v, gap_v, decay_v, limit_v, first_v, restart_v, stop_v);
      set_pace(pace_e'(p % 4));
      // full-rate phase with a long output hold-off: input must back up
      if (p == 4) holds_asked++;
      for (int i = 0; i < FRAMES_PER_PHASE; i++)
        send_frame(i == 0 || $urandom_range(39) == 0, 24'($urandom), 24'($urandom));
    end

    // Long roll: every frame is a one-frame burst, so the burst count climbs
    // all the way to its top before the effect ends.
    program_regs(STEP_W'($urandom), 16'd0, 16'd0, 8'd255, 27'h7FF_FFFF, AMP_W'($urandom),
                 27'h7FF_FFFF);
    set_pace(PACE_BOTH);
    for (int i = 0; i < LONG_ROLL_FRAMES; i++)
      send_frame(i == 0, 24'($urandom), 24'($urandom));

    // Drain, then give a stray word time to show up.
    in_w.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_mixes != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (mix_fail_count == 0 && pending_mixes == 0) begin
      $display("[decaying_sine_kick_roll] OK");
    end else begin
      $display("[decaying_sine_kick_roll] ERROR");
    end
    $finish;
  end

endmodule
